FILE: rtl/cmsf_pkg.sv
// Shared types and constants of the calibrated median sensor filter.
package cmsf_pkg;

   // Fixed field widths of the request and response words
   localparam int CMD_W     = 2;
   localparam int CHAN_W    = 4;
   localparam int SAMPLE_W  = 12;
   localparam int OFFSET_W  = 12;
   localparam int GAIN_W    = 18;
   localparam int FILT_W    = 15;

   // Arithmetic
   localparam int VALUE_W   = 16;                      // stored history value, signed
   localparam int FRAC_BITS = 8;                       // gain is Q10.8
   localparam int DIFF_W    = SAMPLE_W + 1;            // sample - offset, signed
   localparam int PROD_W    = GAIN_W + 1 + DIFF_W;     // signed product
   localparam int CAL_W     = OFFSET_W + GAIN_W;       // {offset, gain}
   localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1 << FRAC_BITS);

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD   = 2'd0,
      CMD_SAMPLE = 2'd1,
      CMD_EMIT   = 2'd2
   } cmd_code_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MULT,
      ST_WRITE,
      ST_LOAD,
      ST_SELECT,
      ST_PUSH
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic clr_step;    // one step of the post-reset clearing sweep
      logic capture;     // request word accepted: latch fields, read calibration
      logic cal_write;   // load word accepted: write calibration entry
      logic mult;        // form gain * (sample - offset)
      logic smp_write;   // scale, saturate and store to history
      logic emit_start;  // begin an emit run
      logic load_step;   // one step of reading a channel's window
      logic sel_step;    // test one rank candidate
      logic push;        // move the result into the response register
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic clr_done;
      logic load_done;
      logic sel_found;
      logic out_free;
      logic emit_last;
   } ctrl_stat_type;

endpackage

FILE: rtl/cmsf_if.sv
// Request and response channel interfaces of the sensor filter.
interface cmsf_req_if;
   logic                          valid;
   logic                          ready;
   logic [cmsf_pkg::CMD_W-1:0]    command;
   logic [cmsf_pkg::CHAN_W-1:0]   channel;
   logic [cmsf_pkg::SAMPLE_W-1:0] sample;
   logic [cmsf_pkg::OFFSET_W-1:0] offset;
   logic [cmsf_pkg::GAIN_W-1:0]   gain;
   logic                          frame_end;

   modport source (output valid, command, channel, sample, offset, gain, frame_end,
                   input ready);
   modport sink   (input valid, command, channel, sample, offset, gain, frame_end,
                   output ready);
endinterface

interface cmsf_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [cmsf_pkg::CHAN_W-1:0] out_channel;
   logic [cmsf_pkg::FILT_W-1:0] filtered;
   logic                        last;

   modport source (output valid, out_channel, filtered, last, input ready);
   modport sink   (input valid, out_channel, filtered, last, output ready);
endinterface

FILE: rtl/calibrated_median_sensor_filter_unit.sv
// Top level of the calibrated median sensor filter: controller, datapath and checks.
//
// Multi-channel line-sensor conditioner. A load word (command 0) stores a
// channel's 12-bit offset and unsigned Q10.8 gain; a sample word (command 1)
// stores gain * (sample - offset), truncated toward zero and saturated to
// signed 16 bits, into the current slot of that channel's WINDOW-deep
// history, and with frame_end set advances the shared slot pointer (wraps at
// WINDOW); an emit word (command 2) returns one response word per channel,
// channels 0 up to min(CHANNELS,16)-1 in order, carrying the rank-WINDOW/2
// value in descending order of its history (the sixth largest of ten),
// negative values reported as zero, with last set on the final channel.
// Load and sample words for channels at or above CHANNELS write nothing,
// though a sample word with frame_end set still advances the slot pointer;
// command 3 is ignored. A sample word passes through a calibration memory
// read, then the multiply; the history write overlaps the next request
// word. An emit runs, per channel, history memory reads (one read port),
// rank testing (one candidate per cycle against the whole window), and
// the hand-off of the word to the response register; a stalled response
// holds the run. The response register lets a new request word enter
// while the last response word still waits. After reset a clearing sweep
// writes every history entry to zero and every calibration entry to gain
// one, offset zero, with req ready low throughout.
module calibrated_median_sensor_filter_unit #(
   parameter int CHANNELS = 16,
   parameter int WINDOW   = 10
) (
   input logic        clock,
   input logic        reset,
   cmsf_req_if.sink   req_port,
   cmsf_rsp_if.source rsp_port
);
   import cmsf_pkg::*;

   ctrl_cmd_type  cmd;
   ctrl_stat_type stat;

   cmsf_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_port.valid),
      .req_command (req_port.command),
      .req_ready   (req_port.ready),
      .stat        (stat),
      .cmd         (cmd)
   );

   cmsf_datapath #(
      .CHANNELS (CHANNELS),
      .WINDOW   (WINDOW)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_channel     (req_port.channel),
      .req_sample      (req_port.sample),
      .req_offset      (req_port.offset),
      .req_gain        (req_port.gain),
      .req_frame_end   (req_port.frame_end),
      .rsp_valid       (rsp_port.valid),
      .rsp_ready       (rsp_port.ready),
      .rsp_out_channel (rsp_port.out_channel),
      .rsp_filtered    (rsp_port.filtered),
      .rsp_last        (rsp_port.last)
   );

   // ---------------- checks ----------------

   // no request word is taken during the clearing sweep or an emit run
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_port.valid && req_port.ready) |-> !(cmd.clr_step || cmd.load_step || cmd.sel_step))
      else $error("request accepted while busy");

   // a push never overwrites a response word that was not taken
   a_push_free: assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> (!rsp_port.valid || rsp_port.ready))
      else $error("response register overwritten");

   // sequencing steps are exclusive
   a_steps_exclusive: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.clr_step, cmd.capture, cmd.mult, cmd.load_step, cmd.sel_step, cmd.push}))
      else $error("conflicting sequencer steps");

   // a pushed word appears on the response channel in the next cycle
   a_push_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.push |=> rsp_port.valid)
      else $error("pushed word not presented");

endmodule

FILE: rtl/cmsf_ctrl.sv
// Sequencing state machine of the sensor filter.
module cmsf_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic [cmsf_pkg::CMD_W-1:0] req_command,
   output logic                       req_ready,
   input  cmsf_pkg::ctrl_stat_type    stat,
   output cmsf_pkg::ctrl_cmd_type     cmd
);
   import cmsf_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      accept    = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (stat.clr_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE, ST_WRITE: begin
            // history write of the previous sample overlaps the next word
            cmd.smp_write = (state_ff == ST_WRITE);
            req_ready     = 1'b1;
            accept        = req_valid;
            state_in      = ST_IDLE;
            if (accept) begin
               cmd.capture = 1'b1;
               unique case (cmd_code_type'(req_command))
                  CMD_LOAD: begin
                     cmd.cal_write = 1'b1;
                  end
                  CMD_SAMPLE: begin
                     state_in = ST_MULT;
                  end
                  CMD_EMIT: begin
                     cmd.emit_start = 1'b1;
                     state_in       = ST_LOAD;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_MULT: begin
            cmd.mult = 1'b1;
            state_in = ST_WRITE;
         end
         ST_LOAD: begin
            cmd.load_step = 1'b1;
            if (stat.load_done) begin
               state_in = ST_SELECT;
            end
         end
         ST_SELECT: begin
            cmd.sel_step = 1'b1;
            if (stat.sel_found) begin
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (stat.out_free) begin
               cmd.push = 1'b1;
               state_in = stat.emit_last ? ST_IDLE : ST_LOAD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: rtl/cmsf_datapath.sv
// Datapath: calibration and history memories, scaler, rank selector, response register.
module cmsf_datapath #(
   parameter int CHANNELS = 16,
   parameter int WINDOW   = 10
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cmsf_pkg::ctrl_cmd_type        cmd,
   output cmsf_pkg::ctrl_stat_type       stat,
   input  logic [cmsf_pkg::CHAN_W-1:0]   req_channel,
   input  logic [cmsf_pkg::SAMPLE_W-1:0] req_sample,
   input  logic [cmsf_pkg::OFFSET_W-1:0] req_offset,
   input  logic [cmsf_pkg::GAIN_W-1:0]   req_gain,
   input  logic                          req_frame_end,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [cmsf_pkg::CHAN_W-1:0]   rsp_out_channel,
   output logic [cmsf_pkg::FILT_W-1:0]   rsp_filtered,
   output logic                          rsp_last
);
   import cmsf_pkg::*;

   localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int SLOT_W = $clog2(WINDOW);
   localparam int CNT_W  = $clog2(WINDOW + 1);
   localparam int DEPTH  = CHANNELS * WINDOW;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int RANK   = WINDOW / 2;
   localparam int EMIT_N = (CHANNELS < (1 << CHAN_W)) ? CHANNELS : (1 << CHAN_W);
   localparam logic [ADDR_W-1:0] WIN_A = ADDR_W'(WINDOW);

   // ---------------- storage ----------------
   logic signed [VALUE_W-1:0] hist_mem [DEPTH];
   logic        [CAL_W-1:0]   cal_mem  [CHANNELS];

   // ---------------- registers ----------------
   logic [ADDR_W-1:0]         clr_addr_ff, clr_addr_in;
   logic [SLOT_W-1:0]         slot_ff, slot_in;
   logic [CH_W-1:0]           chan_ff;
   logic                      in_range_ff;
   logic [SAMPLE_W-1:0]       sample_ff;
   logic                      frame_end_ff;
   logic [CAL_W-1:0]          cal_q_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic [CH_W-1:0]           emit_ch_ff, emit_ch_in;
   logic [ADDR_W-1:0]         rd_addr_ff, rd_addr_in;
   logic [CNT_W-1:0]          ld_cnt_ff, ld_cnt_in;
   logic [SLOT_W-1:0]         sel_idx_ff, sel_idx_in;
   logic signed [VALUE_W-1:0] hist_q_ff;
   logic signed [VALUE_W-1:0] win_ff [WINDOW];
   logic [FILT_W-1:0]         res_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [CHAN_W-1:0]         rsp_chan_ff;
   logic [FILT_W-1:0]         rsp_filt_ff;
   logic                      rsp_last_ff;

   // ---------------- combinational ----------------
   logic                      req_in_range;
   logic [CH_W-1:0]           req_idx;
   logic [OFFSET_W-1:0]       cal_off;
   logic [GAIN_W-1:0]         cal_gain;
   logic signed [DIFF_W-1:0]  diff;
   logic signed [PROD_W-1:0]  prod_in;
   logic signed [PROD_W-1:0]  biased;
   logic signed [PROD_W-1:0]  quot;
   logic [PROD_W-VALUE_W:0]   quot_hi;
   logic signed [VALUE_W-1:0] scaled;
   logic                      hist_we;
   logic [ADDR_W-1:0]         hist_wa;
   logic signed [VALUE_W-1:0] hist_wd;
   logic                      cal_we;
   logic [CH_W-1:0]           cal_wa;
   logic [CAL_W-1:0]          cal_wd;
   logic signed [VALUE_W-1:0] cand;
   logic [WINDOW-1:0]         gt_vec;
   logic [WINDOW-1:0]         ge_vec;
   logic                      found;
   logic                      is_last;

   assign req_in_range = (int'(req_channel) < CHANNELS);
   assign req_idx      = CH_W'(req_channel);

   // ---------------- calibration scaling ----------------
   assign cal_off  = cal_q_ff[CAL_W-1 -: OFFSET_W];
   assign cal_gain = cal_q_ff[GAIN_W-1:0];
   assign diff     = $signed({1'b0, sample_ff}) - $signed({1'b0, cal_off});
   assign prod_in  = $signed({1'b0, cal_gain}) * diff;

   // divide by 2^FRAC_BITS truncating toward zero, then saturate
   assign biased  = prod_ff + (prod_ff[PROD_W-1] ? PROD_W'((1 << FRAC_BITS) - 1) : '0);
   assign quot    = biased >>> FRAC_BITS;
   assign quot_hi = quot[PROD_W-1:VALUE_W-1];

   always_comb begin
      if ((&quot_hi) || (~|quot_hi)) begin
         scaled = quot[VALUE_W-1:0];
      end else if (quot[PROD_W-1]) begin
         scaled = {1'b1, {(VALUE_W-1){1'b0}}};
      end else begin
         scaled = {1'b0, {(VALUE_W-1){1'b1}}};
      end
   end

   // ---------------- memory write ports ----------------
   always_comb begin
      hist_we = 1'b0;
      hist_wa = clr_addr_ff;
      hist_wd = '0;
      if (cmd.clr_step) begin
         hist_we = 1'b1;
      end else if (cmd.smp_write && in_range_ff) begin
         hist_we = 1'b1;
         hist_wa = ADDR_W'(chan_ff) * WIN_A + ADDR_W'(slot_ff);
         hist_wd = scaled;
      end
   end

   always_comb begin
      cal_we = 1'b0;
      cal_wa = req_idx;
      cal_wd = {req_offset, req_gain};
      if (cmd.clr_step) begin
         cal_we = (int'(clr_addr_ff) < CHANNELS);
         cal_wa = CH_W'(clr_addr_ff);
         cal_wd = {{OFFSET_W{1'b0}}, GAIN_ONE};
      end else if (cmd.cal_write) begin
         cal_we = req_in_range;
      end
   end

   always_ff @(posedge clock) begin
      if (hist_we) begin
         hist_mem[hist_wa] <= hist_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_step && (ld_cnt_ff < CNT_W'(WINDOW))) begin
         hist_q_ff <= hist_mem[rd_addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cal_we) begin
         cal_mem[cal_wa] <= cal_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cal_q_ff <= cal_mem[req_idx];
      end
   end

   // ---------------- rank selection ----------------
   assign cand = win_ff[sel_idx_ff];

   always_comb begin
      for (int j = 0; j < WINDOW; j++) begin
         gt_vec[j] = (win_ff[j] >  cand);
         ge_vec[j] = (win_ff[j] >= cand);
      end
   end

   // candidate holds rank RANK when at most RANK values beat it and more tie or beat it
   assign found = (($countones(gt_vec) <= RANK) && ($countones(ge_vec) > RANK))
                  || (sel_idx_ff == SLOT_W'(WINDOW - 1));
   assign is_last = (emit_ch_ff == CH_W'(EMIT_N - 1));

   // ---------------- next values of control registers ----------------
   always_comb begin
      clr_addr_in  = clr_addr_ff;
      slot_in      = slot_ff;
      emit_ch_in   = emit_ch_ff;
      rd_addr_in   = rd_addr_ff;
      ld_cnt_in    = ld_cnt_ff;
      sel_idx_in   = sel_idx_ff;
      rsp_valid_in = rsp_valid_ff;
      if (cmd.clr_step) begin
         clr_addr_in = clr_addr_ff + 1'b1;
      end
      if (cmd.smp_write && frame_end_ff) begin
         slot_in = (slot_ff == SLOT_W'(WINDOW - 1)) ? '0 : slot_ff + 1'b1;
      end
      if (cmd.emit_start) begin
         emit_ch_in = '0;
         rd_addr_in = '0;
         ld_cnt_in  = '0;
         sel_idx_in = '0;
      end
      if (cmd.load_step) begin
         if (ld_cnt_ff < CNT_W'(WINDOW)) begin
            rd_addr_in = rd_addr_ff + 1'b1;
            ld_cnt_in  = ld_cnt_ff + 1'b1;
         end
      end
      if (cmd.sel_step && !found) begin
         sel_idx_in = sel_idx_ff + 1'b1;
      end
      if (cmd.push) begin
         emit_ch_in   = emit_ch_ff + 1'b1;
         ld_cnt_in    = '0;
         sel_idx_in   = '0;
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff  <= '0;
         slot_ff      <= '0;
         emit_ch_ff   <= '0;
         rd_addr_ff   <= '0;
         ld_cnt_ff    <= '0;
         sel_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_addr_ff  <= clr_addr_in;
         slot_ff      <= slot_in;
         emit_ch_ff   <= emit_ch_in;
         rd_addr_ff   <= rd_addr_in;
         ld_cnt_ff    <= ld_cnt_in;
         sel_idx_ff   <= sel_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ---------------- payload registers ----------------
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         chan_ff      <= req_idx;
         in_range_ff  <= req_in_range;
         sample_ff    <= req_sample;
         frame_end_ff <= req_frame_end;
      end
      if (cmd.mult) begin
         prod_ff <= prod_in;
      end
      if (cmd.load_step && (ld_cnt_ff != '0)) begin
         win_ff[SLOT_W'(ld_cnt_ff - 1'b1)] <= hist_q_ff;
      end
      if (cmd.sel_step && found) begin
         res_ff <= cand[VALUE_W-1] ? '0 : cand[FILT_W-1:0];
      end
      if (cmd.push) begin
         rsp_chan_ff <= CHAN_W'(emit_ch_ff);
         rsp_filt_ff <= res_ff;
         rsp_last_ff <= is_last;
      end
   end

   // ---------------- status and outputs ----------------
   assign stat.clr_done  = (clr_addr_ff == ADDR_W'(DEPTH - 1));
   assign stat.load_done = (ld_cnt_ff == CNT_W'(WINDOW));
   assign stat.sel_found = found;
   assign stat.out_free  = !rsp_valid_ff || rsp_ready;
   assign stat.emit_last = is_last;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_channel = rsp_chan_ff;
   assign rsp_filtered    = rsp_filt_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

FILE: test/tb_calibrated_median_sensor_filter_unit.sv
// Testbench for the calibrated median sensor filter: random traffic checked against a model.
module tb_calibrated_median_sensor_filter_unit;
   import cmsf_pkg::*;

   localparam int NUM_CH        = 16;
   localparam int WIN           = 10;
   localparam int RANK          = WIN / 2;       // sixth largest of ten
   localparam int LIMIT_CYCLES  = 400000;
   localparam int SETTLE_CYCLES = 60;
   localparam int PRINT_CAP     = 40;

   // command 3 has no enum member; the block must drop it
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam logic [GAIN_W-1:0] GAIN_MAX   = '1;
   localparam logic [SAMPLE_W-1:0] SMP_MAX  = '1;
   localparam logic [OFFSET_W-1:0] OFF_MAX  = '1;

   typedef struct {
      logic [CMD_W-1:0]    command;
      logic [CHAN_W-1:0]   channel;
      logic [SAMPLE_W-1:0] sample;
      logic [OFFSET_W-1:0] offset;
      logic [GAIN_W-1:0]   gain;
      logic                frame_end;
   } sensor_word_type;

   typedef struct {
      logic [CHAN_W-1:0] channel;
      logic [FILT_W-1:0] filtered;
      logic              last;
   } filtered_word_type;

   logic clock;
   logic reset;

   cmsf_req_if req_bus ();
   cmsf_rsp_if rsp_bus ();

   calibrated_median_sensor_filter_unit #(
      .CHANNELS (NUM_CH),
      .WINDOW   (WIN)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus)
   );

   // ---------------------------------------------------------------
   // Model state: history, calibration tables, shared slot pointer
   // ---------------------------------------------------------------
   logic signed [VALUE_W-1:0] hist_mem [NUM_CH][WIN];
   logic [OFFSET_W-1:0]       offset_mem [NUM_CH];
   logic [GAIN_W-1:0]         gain_mem [NUM_CH];
   int unsigned               slot_ptr;

   filtered_word_type pending_filtered [$];   // responses owed by the block, oldest first

   int  mismatch_count;
   int  cycle_count;
   int  hold_request;     // > 0 asks the response side for a long hold-off, its length set by the value
   bit  no_gaps;          // back-to-back stretch on both sides

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic void clear_model();
      for (int ch = 0; ch < NUM_CH; ch++) begin
         for (int s = 0; s < WIN; s++) hist_mem[ch][s] = '0;
         offset_mem[ch] = '0;
         gain_mem[ch]   = GAIN_ONE;
      end
      slot_ptr = 0;
   endfunction

   // gain * (sample - offset) in Q.8, truncated toward zero, saturated to int16
   function automatic logic signed [VALUE_W-1:0] scaled_reading(logic [SAMPLE_W-1:0] smp,
                                                               logic [OFFSET_W-1:0] off,
                                                               logic [GAIN_W-1:0]   g);
      longint diff;
      longint prod;
      longint v;
      diff = longint'(smp) - longint'(off);
      prod = longint'(g) * diff;
      v    = prod / (longint'(1) << FRAC_BITS);
      if (v > 32767) v = 32767;
      else if (v < -32768) v = -32768;
      return VALUE_W'(v);
   endfunction

   // rank RANK in descending order of one channel's window
   function automatic int ranked_reading(int ch);
      int ranked_vals [WIN];
      int key;
      int j;
      for (int i = 0; i < WIN; i++) ranked_vals[i] = hist_mem[ch][i];
      for (int i = 1; i < WIN; i++) begin
         key = ranked_vals[i];
         j   = i;
         while (j > 0 && ranked_vals[j-1] < key) begin
            ranked_vals[j] = ranked_vals[j-1];
            j--;
         end
         ranked_vals[j] = key;
      end
      return ranked_vals[RANK];
   endfunction

   // Advance the model by one accepted request word
   function automatic void apply_word(sensor_word_type w);
      filtered_word_type r;
      int v;
      case (w.command)
         CMD_LOAD: begin
            offset_mem[w.channel] = w.offset;
            gain_mem[w.channel]   = w.gain;
         end
         CMD_SAMPLE: begin
            hist_mem[w.channel][slot_ptr] =
               scaled_reading(w.sample, offset_mem[w.channel], gain_mem[w.channel]);
            if (w.frame_end) slot_ptr = (slot_ptr == WIN - 1) ? 0 : slot_ptr + 1;
         end
         CMD_EMIT: begin
            for (int ch = 0; ch < NUM_CH; ch++) begin
               v          = ranked_reading(ch);
               r.channel  = CHAN_W'(ch);
               r.filtered = (v < 0) ? '0 : FILT_W'(v);   // negatives clamp to zero
               r.last     = (ch == NUM_CH - 1);
               pending_filtered.push_back(r);
            end
         end
         default: ;   // unused command: no effect
      endcase
   endfunction

   // Mostly short gaps, a few long ones
   function automatic int idle_gap();
      int roll;
      if (no_gaps) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic sensor_word_type make_word(logic [CMD_W-1:0] cmd, logic [CHAN_W-1:0] ch,
                                                 logic [SAMPLE_W-1:0] smp,
                                                 logic [OFFSET_W-1:0] off,
                                                 logic [GAIN_W-1:0] g, logic fe);
      sensor_word_type w;
      w.command   = cmd;
      w.channel   = ch;
      w.sample    = smp;
      w.offset    = off;
      w.gain      = g;
      w.frame_end = fe;
      return w;
   endfunction

   task automatic report_mismatch(string msg);
      mismatch_count++;
      if (mismatch_count <= PRINT_CAP) $display("ERROR @%0t: %s", $realtime, msg);
   endtask

   // Offer one word and return at the edge that accepts it; valid stays high
   // into the next call unless that call opens a gap.
   task automatic send_word(sensor_word_type w);
      int gap;
      gap = idle_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.command   <= w.command;
      req_bus.channel   <= w.channel;
      req_bus.sample    <= w.sample;
      req_bus.offset    <= w.offset;
      req_bus.gain      <= w.gain;
      req_bus.frame_end <= w.frame_end;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      apply_word(w);
   endtask

   task automatic drain_responses();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending_filtered.size() != 0);
   endtask

   // ---------------------------------------------------------------
   // Response side: random stalls plus an on-demand long hold-off
   // ---------------------------------------------------------------
   initial begin : rsp_ready_driver
      int hold_left;
      int stall_left;
      hold_left  = 0;
      stall_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            stall_left = idle_gap();
            rsp_bus.ready <= (stall_left == 0);
         end
      end
   end

   // Compare every accepted response with the oldest owed one
   always @(posedge clock) begin
      filtered_word_type exp_w;
      if (reset === 1'b0 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (pending_filtered.size() == 0) begin
            report_mismatch($sformatf("unexpected word ch=%0d filtered=%0d last=%0b",
                                      rsp_bus.out_channel, rsp_bus.filtered, rsp_bus.last));
         end else begin
            exp_w = pending_filtered.pop_front();
            if (rsp_bus.out_channel !== exp_w.channel)
               report_mismatch($sformatf("out_channel %0d, want %0d",
                                         rsp_bus.out_channel, exp_w.channel));
            if (rsp_bus.filtered !== exp_w.filtered)
               report_mismatch($sformatf("ch %0d filtered %0d, want %0d",
                                         exp_w.channel, rsp_bus.filtered, exp_w.filtered));
            if (rsp_bus.last !== exp_w.last)
               report_mismatch($sformatf("ch %0d last %0b, want %0b",
                                         exp_w.channel, rsp_bus.last, exp_w.last));
         end
      end
   end

   // Watchdog: the clearing sweep, all items and all stalls fit well inside
   initial begin
      cycle_count = 0;
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("calibrated_median_sensor_filter_unit: mismatch");
      $finish;
   end

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------

   // Emit straight after reset: all windows zero
   task automatic test_reset_state();
      send_word(make_word(CMD_EMIT, '0, '0, '0, '0, 1'b0));
   endtask

   // Saturation both ways, truncation toward zero, zero gain, unit gain
   task automatic test_calibration_extremes();
      send_word(make_word(CMD_LOAD,   4'd0, '0, '0, GAIN_MAX, 1'b0));
      send_word(make_word(CMD_SAMPLE, 4'd0, SMP_MAX, '0, '0, 1'b0));
      send_word(make_word(CMD_LOAD,   4'd1, '0, OFF_MAX, GAIN_MAX, 1'b0));
      send_word(make_word(CMD_SAMPLE, 4'd1, '0, '0, '0, 1'b0));
      // -1 * 1.5 = -1.5 truncates to -1
      send_word(make_word(CMD_LOAD,   4'd2, '0, 12'd100, 18'h180, 1'b0));
      send_word(make_word(CMD_SAMPLE, 4'd2, 12'd99, '0, '0, 1'b0));
      send_word(make_word(CMD_LOAD,   4'd3, '0, '0, '0, 1'b0));
      send_word(make_word(CMD_SAMPLE, 4'd3, SMP_MAX, '0, '0, 1'b0));
      send_word(make_word(CMD_SAMPLE, 4'd4, 12'd1234, '0, '0, 1'b1));
      send_word(make_word(CMD_LOAD,   4'd15, '0, OFF_MAX, 18'd1, 1'b0));
      send_word(make_word(CMD_SAMPLE, 4'd15, SMP_MAX, '0, '0, 1'b1));
      send_word(make_word(CMD_EMIT,   '0, '0, '0, '0, 1'b0));
   endtask

   // Unused command, frame_end on load and emit: no slot advance
   task automatic test_ignored_words();
      send_word(make_word(CMD_UNUSED, 4'd15, SMP_MAX, OFF_MAX, GAIN_MAX, 1'b1));
      send_word(make_word(CMD_LOAD,   4'd5, '0, 12'd7, 18'd512, 1'b1));
      send_word(make_word(CMD_EMIT,   4'd15, SMP_MAX, OFF_MAX, GAIN_MAX, 1'b1));
      send_word(make_word(CMD_SAMPLE, 4'd5, 12'd2000, '0, '0, 1'b0));
      send_word(make_word(CMD_EMIT,   '0, '0, '0, '0, 1'b0));
      drain_responses();
   endtask

   // Frames of samples, mostly on a few channels so their windows fill up,
   // with loads, emits and some unused-command noise mixed in.
   function automatic sensor_word_type random_word();
      sensor_word_type w;
      int pick;
      int g_roll;
      w.channel   = ($urandom_range(0, 9) < 7) ? CHAN_W'($urandom_range(0, 3))
                                               : CHAN_W'($urandom_range(0, NUM_CH - 1));
      w.sample    = ($urandom_range(0, 9) == 0) ? (($urandom_range(0, 1) != 0) ? SMP_MAX : '0)
                                                : SAMPLE_W'($urandom());
      w.offset    = OFFSET_W'($urandom());
      g_roll      = $urandom_range(0, 99);
      if (g_roll < 25)      w.gain = GAIN_ONE;
      else if (g_roll < 33) w.gain = '0;
      else if (g_roll < 41) w.gain = GAIN_MAX;
      else if (g_roll < 85) w.gain = GAIN_W'($urandom_range(0, 1023));
      else                  w.gain = GAIN_W'($urandom());
      w.frame_end = 1'b0;
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
         w.command   = CMD_SAMPLE;
         w.frame_end = ($urandom_range(0, 2) == 0);
      end else if (pick < 75) begin
         w.command = CMD_LOAD;
         w.frame_end = ($urandom_range(0, 1) != 0);
      end else if (pick < 92) begin
         w.command = CMD_EMIT;
         w.frame_end = ($urandom_range(0, 1) != 0);
      end else begin
         w.command = CMD_UNUSED;
      end
      return w;
   endfunction

   task automatic test_random_traffic(int n_words);
      sensor_word_type w;
      int sent;
      sent = 0;
      while (sent < n_words) begin
         w = random_word();
         send_word(w);
         if (w.command != CMD_UNUSED) sent++;
      end
   endtask

   // Response side holds off while emits keep coming: the block fills and
   // must stall its request input until the hold ends.
   task automatic test_output_backpressure();
      drain_responses();
      hold_request = 400;
      repeat (4) send_word(make_word(CMD_EMIT, '0, '0, '0, '0, 1'b0));
      test_random_traffic(10);
   endtask

   task automatic test_back_to_back(int n_words);
      no_gaps = 1'b1;
      test_random_traffic(n_words);
      no_gaps = 1'b0;
   endtask

   initial begin
      mismatch_count = 0;
      hold_request   = 0;
      no_gaps        = 1'b0;
      clear_model();
      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.command   <= '0;
      req_bus.channel   <= '0;
      req_bus.sample    <= '0;
      req_bus.offset    <= '0;
      req_bus.gain      <= '0;
      req_bus.frame_end <= 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_calibration_extremes();
      test_ignored_words();
      test_random_traffic(80);
      test_output_backpressure();
      test_back_to_back(50);
      test_random_traffic(30);

      drain_responses();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_filtered.size() == 0) begin
         $display("calibrated_median_sensor_filter_unit: match");
      end else begin
         $display("calibrated_median_sensor_filter_unit: mismatch");
      end
      $finish;
   end

endmodule
